@@ hw/rtl/magnetometer_scale_offset_calibrator_top_macros.svh @@
// Assertion macros for the magnetometer calibrator.
// Both check at the rising edge of clk. The first is held off while rst_n is low.
// The second also checks while reset is asserted.
`ifndef MAGNETOMETER_SCALE_OFFSET_CALIBRATOR_TOP_MACROS_SVH
`define MAGNETOMETER_SCALE_OFFSET_CALIBRATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define MSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSC_ASSERT(label, prop, msg)
`define MSC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ hw/rtl/mscal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mscal_pkg;

    // Operation codes carried in requests and echoed in results.
    typedef enum logic [1:0]
    {
        OP_MEASURE = 2'd0,
        OP_CALIB   = 2'd1,
        OP_CLOSE   = 2'd2,
        OP_UNDEF   = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_X  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_Y  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_Z  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT  = 3'd4;

    localparam int unsigned CFG_DATA_W = 24;

    // Reset values: gain 0.92 mG per count in Q4.12, limit 600 mG in 1/16 mG.
    localparam logic [15:0] GAIN_RESET  = 16'd3768;
    localparam logic [22:0] LIMIT_RESET = 23'd9600;

    localparam logic signed [23:0] FIELD_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] FIELD_MIN = -24'sh800000;

    typedef struct packed
    {
        op_t                op;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
    } in_t;

    typedef struct packed
    {
        op_t                kind;
        logic signed [23:0] field_x;
        logic signed [23:0] field_y;
        logic signed [23:0] field_z;
        logic               accepted;
        logic               offsets_valid;
    } out_t;

    // Scaled sample between the two stages.
    typedef struct packed
    {
        op_t                op;
        logic signed [23:0] scaled_x;
        logic signed [23:0] scaled_y;
        logic signed [23:0] scaled_z;
    } scaled_t;

    // Live configuration.
    typedef struct packed
    {
        logic [15:0]        gain_q12;
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic signed [23:0] offset_z;
        logic [22:0]        outlier_limit;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/mscal_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mscal_scale
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire logic               drain,
    input  wire mscal_pkg::in_t     req,
    input  wire logic [15:0]        gain_q12,
    output logic                    s1_valid,
    output mscal_pkg::scaled_t      s1_data
);

    // Round-to-nearest scale from Q12 mG to 1/16 mG; the result always fits 24 bits.
    function automatic logic signed [23:0] scale_axis
    (
        input logic signed [15:0] raw,
        input logic [15:0]        gain
    );
        logic signed [32:0] prod;
        logic signed [33:0] rounded;
        logic signed [33:0] shifted;
        prod    = raw * signed'({1'b0, gain});
        rounded = {prod[32], prod} + 34'sd128;
        shifted = rounded >>> 8;
        return shifted[23:0];
    endfunction

    logic signed [15:0]  held_x_reg, held_y_reg, held_z_reg;
    logic                zero_sample;
    logic signed [15:0]  sel_x, sel_y, sel_z;
    logic                s1_valid_reg, s1_valid_next;
    mscal_pkg::scaled_t  s1_data_reg, s1_data_next;

    // An all-zero sample falls back to the last non-zero one.
    assign zero_sample = (req.raw_x == 16'sd0) && (req.raw_y == 16'sd0) &&
                         (req.raw_z == 16'sd0);
    assign sel_x = zero_sample ? held_x_reg : req.raw_x;
    assign sel_y = zero_sample ? held_y_reg : req.raw_y;
    assign sel_z = zero_sample ? held_z_reg : req.raw_z;

    // Stage payload and occupancy.
    always_comb
    begin
        s1_data_next          = s1_data_reg;
        s1_data_next.op       = req.op;
        s1_data_next.scaled_x = scale_axis(sel_x, gain_q12);
        s1_data_next.scaled_y = scale_axis(sel_y, gain_q12);
        s1_data_next.scaled_z = scale_axis(sel_z, gain_q12);
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (drain)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Held sample and stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg   <= '0;
            held_y_reg   <= '0;
            held_z_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (load && !zero_sample)
            begin
                held_x_reg <= req.raw_x;
                held_y_reg <= req.raw_y;
                held_z_reg <= req.raw_z;
            end
        end
    end

    // Stage payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_data_reg <= s1_data_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mscal_track.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mscal_track
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic               out_stall,
    input  wire mscal_pkg::scaled_t s1_data,
    input  wire mscal_pkg::cfg_t    cfg,
    output logic                    out_valid,
    output mscal_pkg::out_t         out_data
);

    logic signed [23:0] min_reg [3];
    logic signed [23:0] max_reg [3];
    logic signed [23:0] min_next [3];
    logic signed [23:0] max_next [3];
    logic               seen_reg, seen_next;
    logic               out_valid_reg, out_valid_next;
    mscal_pkg::out_t    out_data_reg, out_data_next;

    logic signed [23:0] scaled [3];
    logic signed [23:0] offs [3];
    logic signed [23:0] meas [3];
    logic signed [23:0] mid [3];
    logic [23:0]        mag [3];
    logic signed [24:0] sum_off [3];
    logic signed [24:0] sum_mid [3];
    logic               in_limit;

    assign scaled[0] = s1_data.scaled_x;
    assign scaled[1] = s1_data.scaled_y;
    assign scaled[2] = s1_data.scaled_z;
    assign offs[0]   = cfg.offset_x;
    assign offs[1]   = cfg.offset_y;
    assign offs[2]   = cfg.offset_z;

    // Per-axis measurement, magnitude and midpoint.
    always_comb
    begin
        in_limit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            sum_off[i] = {scaled[i][23], scaled[i]} + {offs[i][23], offs[i]};
            if (sum_off[i][24] != sum_off[i][23])
            begin
                meas[i] = sum_off[i][24] ? mscal_pkg::FIELD_MIN : mscal_pkg::FIELD_MAX;
            end
            else
            begin
                meas[i] = sum_off[i][23:0];
            end
            mag[i] = scaled[i][23] ? (~scaled[i] + 24'd1) : scaled[i];
            if (mag[i] > {1'b0, cfg.outlier_limit})
            begin
                in_limit = 1'b0;
            end
            sum_mid[i] = ({max_reg[i][23], max_reg[i]} + {min_reg[i][23], min_reg[i]}) >>> 1;
            mid[i]     = seen_reg ? sum_mid[i][23:0] : 24'sd0;
        end
    end

    // Result and tracker update for the request leaving the scale stage.
    always_comb
    begin
        seen_next     = seen_reg;
        out_data_next = out_data_reg;
        for (int i = 0; i < 3; i++)
        begin
            min_next[i] = min_reg[i];
            max_next[i] = max_reg[i];
        end
        out_data_next.kind          = s1_data.op;
        out_data_next.accepted      = 1'b0;
        out_data_next.offsets_valid = 1'b0;
        out_data_next.field_x       = scaled[0];
        out_data_next.field_y       = scaled[1];
        out_data_next.field_z       = scaled[2];
        case (s1_data.op)
            mscal_pkg::OP_MEASURE:
            begin
                out_data_next.field_x = meas[0];
                out_data_next.field_y = meas[1];
                out_data_next.field_z = meas[2];
            end
            mscal_pkg::OP_CALIB:
            begin
                out_data_next.accepted = in_limit;
                if (in_limit)
                begin
                    seen_next = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (scaled[i] < min_reg[i])
                        begin
                            min_next[i] = scaled[i];
                        end
                        if (scaled[i] > max_reg[i])
                        begin
                            max_next[i] = scaled[i];
                        end
                    end
                end
            end
            mscal_pkg::OP_CLOSE:
            begin
                out_data_next.field_x       = mid[0];
                out_data_next.field_y       = mid[1];
                out_data_next.field_z       = mid[2];
                out_data_next.offsets_valid = seen_reg;
                seen_next = 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    min_next[i] = mscal_pkg::FIELD_MAX;
                    max_next[i] = mscal_pkg::FIELD_MIN;
                end
            end
            default:
            begin
                // Undefined op: no result and trackers untouched.
            end
        endcase

        // The output register is free whenever the scale stage fires.
        if (fire)
        begin
            out_valid_next = (s1_data.op != mscal_pkg::OP_UNDEF);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Trackers and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= mscal_pkg::FIELD_MAX;
                max_reg[i] <= mscal_pkg::FIELD_MIN;
            end
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    min_reg[i] <= min_next[i];
                    max_reg[i] <= max_next[i];
                end
                seen_reg <= seen_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/magnetometer_scale_offset_calibrator_top.sv @@
// Magnetometer scaler with hard-iron min/max calibration.
// Input channel in_valid/in_stall/in_data carries one request: an op code and
// three signed 16-bit axis counts. Output channel out_valid/out_stall/out_data
// returns one result per request, except for the undefined op, which
// returns nothing. The configuration port (cfg_we, cfg_index, cfg_data)
// writes gain, the three offsets and the outlier limit, one register per edge.
// Between acceptance and out_valid lie two registers: the first register
// holds the scaled sample (one 16x17 multiply per axis), the second holds
// the result after offset, outlier test, min/max tracking or midpoint.
// Throughput is one request per cycle while out_stall is low, as set by the
// two-register pipeline; tracker state is read and written in stage 2 only.
// While out_stall is high with a result waiting, the scale stage still
// takes one more request; after that, in_stall rises until the output drains.
// Reset clears the held sample to zero, sets the trackers empty, and loads
// gain 0.92 mG per count, zero offsets and a 600 mG outlier limit.
`timescale 1ns / 1ps
`default_nettype none
`include "magnetometer_scale_offset_calibrator_top_macros.svh"

module magnetometer_scale_offset_calibrator_top
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire mscal_pkg::in_t                        in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output mscal_pkg::out_t                            out_data,
    input  wire logic                                  cfg_we,
    input  wire logic [mscal_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [mscal_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mscal_pkg::cfg_t    cfg_reg;
    logic               s1_valid;
    mscal_pkg::scaled_t s1_data;
    logic               out_free;
    logic               fire;
    logic               load;
    logic               undef_kind;
    logic               stray_accept;
    logic               stray_offsets;

    // Pipeline flow: the output register is free when empty or being taken.
    assign out_free = !out_valid || !out_stall;
    assign fire     = s1_valid && out_free;
    assign in_stall = s1_valid && !out_free;
    assign load     = in_valid && !in_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_q12      <= mscal_pkg::GAIN_RESET;
            cfg_reg.offset_x      <= '0;
            cfg_reg.offset_y      <= '0;
            cfg_reg.offset_z      <= '0;
            cfg_reg.outlier_limit <= mscal_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mscal_pkg::REG_GAIN:  cfg_reg.gain_q12      <= cfg_data[15:0];
                mscal_pkg::REG_OFF_X: cfg_reg.offset_x      <= cfg_data;
                mscal_pkg::REG_OFF_Y: cfg_reg.offset_y      <= cfg_data;
                mscal_pkg::REG_OFF_Z: cfg_reg.offset_z      <= cfg_data;
                mscal_pkg::REG_LIMIT: cfg_reg.outlier_limit <= cfg_data[22:0];
                default:
                begin
                    // Unused index: write ignored.
                end
            endcase
        end
    end

    // Scale stage.
    mscal_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .drain    (fire),
        .req      (in_data),
        .gain_q12 (cfg_reg.gain_q12),
        .s1_valid (s1_valid),
        .s1_data  (s1_data)
    );

    // Offset, tracking and result stage.
    mscal_track u_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .out_stall (out_stall),
        .s1_data   (s1_data),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Flags that must never show up on a result.
    assign undef_kind    = (out_data.kind == mscal_pkg::OP_UNDEF);
    assign stray_accept  = out_data.accepted && (out_data.kind != mscal_pkg::OP_CALIB);
    assign stray_offsets = out_data.offsets_valid && (out_data.kind != mscal_pkg::OP_CLOSE);

    // Checks on the block's own logic.
    `MSC_ASSERT(a_no_undef_result, out_valid |-> !undef_kind, "undefined op produced a result")
    `MSC_ASSERT(a_accept_only_calib, out_valid |-> !stray_accept, "stray accepted flag")
    `MSC_ASSERT(a_valid_only_close, out_valid |-> !stray_offsets, "stray offsets_valid flag")
    `MSC_ASSERT_ALWAYS(a_stall_full, in_stall |-> !out_free, "input stalled while output free")

endmodule

`default_nettype wire

@@ test/tb_magnetometer_scale_offset_calibrator_top.sv @@
`timescale 1ns / 1ps

module tb_magnetometer_scale_offset_calibrator_top;

    import mscal_pkg::*;

    localparam int unsigned DRAIN_PAD   = 6;
    localparam int unsigned LONG_HOLD   = 48;
    localparam int unsigned BURST_LEN   = 16;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_ITEMS = 90;
    localparam int unsigned UNITY_ROW   = 7;
    localparam int unsigned DIR_ROWS    = 23;
    localparam int unsigned MAX_REPORTS = 60;
    localparam longint      TIMEOUT_NS  = 1000000;

    // One row of the directed table: a request and, where it is obvious,
    // the result typed in by hand.
    typedef struct
    {
        in_t  req;
        bit   typed;
        out_t want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the calibrator state and its live settings.
    cfg_t live_settings;
    logic signed [15:0] held_counts [3];
    longint lo_track [3];
    longint hi_track [3];
    bit track_seen;

    out_t expected_outputs [$];
    int unsigned err_count = 0;
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    bit hold_request = 1'b0;

    // Directed requests. The first rows run with the reset settings, the rest
    // with unity gain, extreme offsets and a limit of 1000.
    step_row_t directed_steps [DIR_ROWS] = '{
        '{'{OP_CLOSE,   16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{OP_CLOSE, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}},
        '{'{OP_MEASURE, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{OP_MEASURE, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}},
        '{'{OP_CALIB,   16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{OP_CALIB, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0}},
        '{'{OP_CLOSE,   16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{OP_CLOSE, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b1}},
        '{'{OP_MEASURE, 16'sh7FFF, 16'sh8000, 16'sd1}, 1'b0, '0},
        '{'{OP_MEASURE, 16'sd16, -16'sd16, 16'sh8000}, 1'b0, '0},
        '{'{OP_CALIB,   16'sh7FFF, 16'sd5, 16'sd5}, 1'b0, '0},
        '{'{OP_MEASURE, 16'sh7FFF, 16'sh8000, 16'sd0}, 1'b1,
          '{OP_MEASURE, FIELD_MAX, FIELD_MIN, 24'sd5, 1'b0, 1'b0}},
        '{'{OP_MEASURE, 16'sh8000, 16'sh7FFF, -16'sd1}, 1'b0, '0},
        '{'{OP_CALIB,   16'sd1000, -16'sd1000, 16'sd7}, 1'b1,
          '{OP_CALIB, 24'sd1000, -24'sd1000, 24'sd7, 1'b1, 1'b0}},
        '{'{OP_CALIB,   16'sd1001, 16'sd0, 16'sd0}, 1'b1,
          '{OP_CALIB, 24'sd1001, 24'sd0, 24'sd0, 1'b0, 1'b0}},
        '{'{OP_CALIB,   16'sd0, 16'sd0, -16'sd1001}, 1'b1,
          '{OP_CALIB, 24'sd0, 24'sd0, -24'sd1001, 1'b0, 1'b0}},
        '{'{OP_CALIB,   16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{OP_CALIB,   -16'sd3, 16'sd4, 16'sd10}, 1'b0, '0},
        '{'{OP_CLOSE,   16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{OP_CLOSE,   16'sd7, 16'sd7, 16'sd7}, 1'b1,
          '{OP_CLOSE, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}},
        '{'{OP_UNDEF,   16'sd5, 16'sd6, 16'sd7}, 1'b0, '0},
        '{'{OP_MEASURE, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{OP_CALIB,   -16'sd1, -16'sd2, 16'sd3}, 1'b0, '0},
        '{'{OP_CALIB,   -16'sd2, 16'sd1, 16'sd4}, 1'b0, '0},
        '{'{OP_CLOSE,   16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{OP_CALIB,   16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{OP_MEASURE, -16'sd1, -16'sd1, -16'sd1}, 1'b0, '0}
    };

    magnetometer_scale_offset_calibrator_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp24(input longint v);
        if (v > longint'(FIELD_MAX))
            return longint'(FIELD_MAX);
        if (v < longint'(FIELD_MIN))
            return longint'(FIELD_MIN);
        return v;
    endfunction

    function automatic void empty_trackers();
        for (int i = 0; i < 3; i++)
        begin
            lo_track[i] = longint'(FIELD_MAX);
            hi_track[i] = longint'(FIELD_MIN);
        end
        track_seen = 1'b0;
    endfunction

    // Works out the result of one accepted request and advances the shadow
    // state. Returns zero when the request produces no result.
    function automatic bit predict_output(input in_t req, output out_t res);
        logic signed [15:0] smp [3];
        longint scaled [3];
        longint offs [3];
        longint fld [3];
        longint mag;
        bit keep;
        res = '0;
        smp[0] = req.raw_x;
        smp[1] = req.raw_y;
        smp[2] = req.raw_z;
        // An all-zero sample reuses the last non-zero one.
        if (smp[0] != 0 || smp[1] != 0 || smp[2] != 0)
            held_counts = smp;
        offs[0] = longint'(live_settings.offset_x);
        offs[1] = longint'(live_settings.offset_y);
        offs[2] = longint'(live_settings.offset_z);
        // Q12 product rounded to 1/16 mG, ties toward plus infinity.
        for (int i = 0; i < 3; i++)
            scaled[i] = (longint'(held_counts[i]) * longint'(live_settings.gain_q12)
                         + 128) >>> 8;
        if (req.op == OP_UNDEF)
            return 1'b0;
        keep = 1'b1;
        case (req.op)
            OP_MEASURE:
            begin
                for (int i = 0; i < 3; i++)
                    fld[i] = clamp24(scaled[i] + offs[i]);
            end
            OP_CALIB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    fld[i] = scaled[i];
                    mag = scaled[i] < 0 ? -scaled[i] : scaled[i];
                    if (mag > longint'(live_settings.outlier_limit))
                        keep = 1'b0;
                end
                if (keep)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (fld[i] < lo_track[i])
                            lo_track[i] = fld[i];
                        if (fld[i] > hi_track[i])
                            hi_track[i] = fld[i];
                    end
                    track_seen = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            default:
            begin
                res.offsets_valid = track_seen;
                for (int i = 0; i < 3; i++)
                    fld[i] = track_seen ? (hi_track[i] + lo_track[i]) >>> 1 : 0;
                empty_trackers();
            end
        endcase
        res.kind = req.op;
        res.field_x = 24'(fld[0]);
        res.field_y = 24'(fld[1]);
        res.field_z = 24'(fld[2]);
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] random_axis();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sd0;
            3, 4: return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t make_request(input op_t op);
        in_t req;
        req.op = op;
        if ($urandom_range(0, 11) == 0)
        begin
            req.raw_x = '0;
            req.raw_y = '0;
            req.raw_z = '0;
        end
        else
        begin
            req.raw_x = random_axis();
            req.raw_y = random_axis();
            req.raw_z = random_axis();
        end
        return req;
    endfunction

    // Settings for each random phase: reset values, both extremes, then
    // random ones.
    function automatic cfg_t phase_setting(input int unsigned p);
        cfg_t s;
        case (p)
            0: s = '{GAIN_RESET, 24'sd0, 24'sd0, 24'sd0, LIMIT_RESET};
            1: s = '{16'd0, FIELD_MIN, FIELD_MAX, 24'sd0, 23'd0};
            2: s = '{16'hFFFF, FIELD_MAX, FIELD_MIN, 24'($urandom), 23'h7FFFFF};
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    s.gain_q12 = 16'($urandom);
                    s.offset_x = 24'($urandom);
                    s.offset_y = 24'($urandom);
                    s.offset_z = 24'($urandom);
                    s.outlier_limit = 23'($urandom);
                end
                else
                begin
                    s.gain_q12 = 16'($urandom_range(64, 6000));
                    s.offset_x = 24'(int'($urandom_range(0, 200000)) - 100000);
                    s.offset_y = 24'(int'($urandom_range(0, 200000)) - 100000);
                    s.offset_z = 24'(int'($urandom_range(0, 200000)) - 100000);
                    s.outlier_limit = 23'($urandom_range(0, 300000));
                end
            end
        endcase
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Writes all five registers back to back; only called while idle.
    task automatic apply_settings(input cfg_t s);
        write_reg(REG_GAIN, {8'd0, s.gain_q12});
        write_reg(REG_OFF_X, s.offset_x);
        write_reg(REG_OFF_Y, s.offset_y);
        write_reg(REG_OFF_Z, s.offset_z);
        write_reg(REG_LIMIT, {1'b0, s.outlier_limit});
        cfg_we <= 1'b0;
        live_settings = s;
    endtask

    // Offers one request, holds it until accepted, then records its result.
    task automatic send_request(input in_t req, input bit typed = 1'b0,
                                input out_t want = '0);
        int unsigned gap;
        out_t res;
        gap = send_idle_en ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_output(req, res))
            expected_outputs.push_back(typed ? want : res);
    endtask

    // Stops offering and waits until every result is back, then pads the wait
    // for requests that produce nothing.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // Mostly calibration sessions closed by a close request, mixed with
    // measurements, stray closes and undefined-op noise.
    task automatic run_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned span;
        int unsigned pick;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
            begin
                span = $urandom_range(1, 8);
                repeat (span)
                begin
                    send_request(make_request(OP_CALIB));
                    sent++;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_request(make_request(OP_MEASURE));
                        sent++;
                    end
                end
                send_request(make_request(OP_CLOSE));
                sent++;
            end
            else if (pick <= 7)
            begin
                send_request(make_request(OP_MEASURE));
                sent++;
            end
            else if (pick == 8)
            begin
                send_request(make_request(OP_UNDEF));
            end
            else
            begin
                send_request(make_request(OP_CLOSE));
                sent++;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic signed [23:0] want,
                                 input logic signed [23:0] got);
        if (got !== want)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    // Result side: random stalls, the long hold on request, and the check of
    // each accepted result against the oldest expectation.
    initial
    begin : result_monitor
        int unsigned stall_len;
        out_t want;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (recv_idle_en)
            begin
                stall_len = $urandom_range(0, 11);
                if (stall_len != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (stall_len) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid && !hold_request)
                @(posedge clk);
            if (out_valid)
            begin
                if (expected_outputs.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %p",
                                 $time, out_data);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    compare_field("kind", {22'd0, want.kind}, {22'd0, out_data.kind});
                    compare_field("field_x", want.field_x, out_data.field_x);
                    compare_field("field_y", want.field_y, out_data.field_y);
                    compare_field("field_z", want.field_z, out_data.field_z);
                    compare_field("accepted", {23'd0, want.accepted},
                                  {23'd0, out_data.accepted});
                    compare_field("offsets_valid", {23'd0, want.offsets_valid},
                                  {23'd0, out_data.offsets_valid});
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial
    begin : stimulus
        cfg_t unity;
        live_settings = '{GAIN_RESET, 24'sd0, 24'sd0, 24'sd0, LIMIT_RESET};
        for (int i = 0; i < 3; i++)
            held_counts[i] = '0;
        empty_trackers();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; switch to unity gain and extreme offsets midway.
        unity = '{16'd256, FIELD_MAX, FIELD_MIN, 24'sd5, 23'd1000};
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == UNITY_ROW)
            begin
                wait_for_drain();
                apply_settings(unity);
            end
            send_request(directed_steps[i].req, directed_steps[i].typed,
                         directed_steps[i].want);
        end

        for (int unsigned p = 0; p < PHASES; p++)
        begin
            wait_for_drain();
            apply_settings(phase_setting(p));
            send_idle_en = (p % 4 == 0) || (p % 4 == 1);
            recv_idle_en = (p % 4 == 0) || (p % 4 == 2);
            if (p == 3)
            begin
                // Hold the result side off while requests keep coming.
                hold_request = 1'b1;
                repeat (BURST_LEN) send_request(make_request(OP_MEASURE));
            end
            run_phase(PHASE_ITEMS / 2);
            if (p == 5)
                wait_for_drain();
            run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
        end

        wait_for_drain();
        if (err_count == 0 && expected_outputs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
